// ===== hdl/sdfc_pkg.sv =====
// Package for the SD SPI frame and CRC unit: codes, widths, item types
// and the CRC7 / CRC16 byte update functions. No dependencies.
`default_nettype none

package sdfc_pkg;

    localparam int FRAME_MAX = 6;
    localparam int CMD_BYTES = 6;
    localparam int CNT_W     = $clog2(FRAME_MAX + 1);
    localparam int POS_W     = $clog2(FRAME_MAX);

    localparam logic [7:0]  START_BITS = 8'h40;
    localparam logic [7:0]  STOP_BIT   = 8'h01;
    localparam logic [6:0]  CRC7_POLY  = 7'h09;
    localparam logic [15:0] CRC16_POLY = 16'h1021;

    typedef enum logic [1:0] {
        OP_CMD    = 2'd0,
        OP_DATA   = 2'd1,
        OP_FINISH = 2'd2
    } t_opcode;

    typedef struct packed {
        logic [FRAME_MAX-1:0][7:0] bytes;
        logic [CNT_W-1:0]          cnt;
        logic [15:0]               next_crc;
    } t_frame;

    function automatic logic [6:0] crc7_byte(input logic [6:0] crc, input logic [7:0] b);
        logic [6:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[6] ^ b[i];
            c  = {c[5:0], 1'b0};
            if (fb) begin
                c = c ^ CRC7_POLY;
            end
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC16_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sdfc_if.sv =====
// Channel interfaces of the SD SPI frame and CRC unit: input items,
// result items and the configuration write channel. No dependencies.
`default_nettype none

interface sdfc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic [7:0]  data_byte;
    modport source (output valid, output opcode, output cmd_index, output argument,
                    output data_byte, input ready);
    modport sink   (input valid, input opcode, input cmd_index, input argument,
                    input data_byte, output ready);
endinterface

interface sdfc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

interface sdfc_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/sd_spi_frame_crc_unit.sv =====
// Top level of the SD SPI frame and CRC unit: input register, frame
// register with byte sequencer, data CRC and enable registers.
// Depends on sdfc_pkg, sdfc_if and sdfc_builder.
//
// Usage:
//   i_in carries items: opcode 0 builds a six-byte command frame (start
//   byte, argument MSB first, CRC7 with stop bit), opcode 1 passes a data
//   byte and folds it into the running CRC16, opcode 2 sends the CRC16
//   high then low byte (zeros when crc_enable is 0) and clears it.
//   Opcode 3 is dropped without any byte.
//   o_out: one byte per cycle when ready; last marks an item's final byte.
//   i_cfg writes crc_enable; write it only while the block is idle.
// Timing:
//   The first byte of an item is offered from the frame register once the
//   item has passed through the input register.
//   Data items sustain one item per cycle while o_out.ready is high; a
//   command item holds the frame register for its six bytes and a finish
//   item for its two, since the frame register sends one byte per cycle.
// Reset and stalls:
//   Reset empties both registers, clears the CRC and crc_enable.
//   When o_out.ready is low the current byte holds, one more item waits in
//   the input register, then i_in.ready drops.
`default_nettype none

module sd_spi_frame_crc_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sdfc_in_if.sink     i_in,
    sdfc_out_if.source  o_out,
    sdfc_cfg_if.sink    i_cfg
);

    logic        r_in_vld;
    logic [1:0]  r_op;
    logic [5:0]  r_idx;
    logic [31:0] r_arg;
    logic [7:0]  r_db;

    logic                                  r_fr_vld;
    logic [sdfc_pkg::FRAME_MAX-1:0][7:0]   r_fr_bytes;
    logic [sdfc_pkg::CNT_W-1:0]            r_fr_cnt;
    logic [sdfc_pkg::POS_W-1:0]            r_fr_pos;
    logic [sdfc_pkg::POS_W-1:0]            n_fr_pos;

    logic [15:0] r_crc;
    logic        r_crc_en;

    sdfc_pkg::t_frame frame;

    logic last_byte;
    logic fr_done;
    logic fr_free;
    logic move;

    sdfc_builder u_builder (
        .i_opcode    (r_op),
        .i_cmd_index (r_idx),
        .i_argument  (r_arg),
        .i_data_byte (r_db),
        .i_crc       (r_crc),
        .i_crc_en    (r_crc_en),
        .o_frame     (frame)
    );

    assign last_byte = (r_fr_pos == sdfc_pkg::POS_W'(r_fr_cnt - sdfc_pkg::CNT_W'(1)));
    assign fr_done   = r_fr_vld && o_out.ready && last_byte;
    assign fr_free   = !r_fr_vld || fr_done;
    assign move      = r_in_vld && fr_free;
    assign n_fr_pos  = r_fr_pos + sdfc_pkg::POS_W'(1);

    assign i_in.ready     = !r_in_vld || move;
    assign o_out.valid    = r_fr_vld;
    assign o_out.out_byte = r_fr_bytes[r_fr_pos];
    assign o_out.last     = last_byte;
    assign i_cfg.ready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_vld <= 1'b1;
        end else if (move) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op  <= i_in.opcode;
            r_idx <= i_in.cmd_index;
            r_arg <= i_in.argument;
            r_db  <= i_in.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fr_vld <= 1'b0;
            r_fr_pos <= '0;
            r_crc    <= 16'd0;
        end else if (move) begin
            r_fr_vld <= (frame.cnt != '0);
            r_fr_pos <= '0;
            r_crc    <= frame.next_crc;
        end else if (fr_done) begin
            r_fr_vld <= 1'b0;
        end else if (r_fr_vld && o_out.ready) begin
            r_fr_pos <= n_fr_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_fr_bytes <= frame.bytes;
            r_fr_cnt   <= frame.cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_en <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_crc_en <= i_cfg.data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sdfc_builder.sv =====
// Frame builder: turns one registered item into its transmit bytes and
// the next data CRC. Depends on sdfc_pkg.
`default_nettype none

module sdfc_builder (
    input  wire logic [1:0]      i_opcode,
    input  wire logic [5:0]      i_cmd_index,
    input  wire logic [31:0]     i_argument,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic [15:0]     i_crc,
    input  wire logic            i_crc_en,
    output sdfc_pkg::t_frame     o_frame
);

    logic [7:0]  b0;
    logic [6:0]  c7;
    logic [15:0] fin;

    always_comb begin
        b0  = sdfc_pkg::START_BITS | {2'b00, i_cmd_index};
        c7  = sdfc_pkg::crc7_byte(7'd0, b0);
        c7  = sdfc_pkg::crc7_byte(c7, i_argument[31:24]);
        c7  = sdfc_pkg::crc7_byte(c7, i_argument[23:16]);
        c7  = sdfc_pkg::crc7_byte(c7, i_argument[15:8]);
        c7  = sdfc_pkg::crc7_byte(c7, i_argument[7:0]);
        fin = i_crc_en ? i_crc : 16'd0;

        o_frame          = '0;
        o_frame.next_crc = i_crc;
        case (sdfc_pkg::t_opcode'(i_opcode))
            sdfc_pkg::OP_CMD: begin
                o_frame.bytes[0] = b0;
                o_frame.bytes[1] = i_argument[31:24];
                o_frame.bytes[2] = i_argument[23:16];
                o_frame.bytes[3] = i_argument[15:8];
                o_frame.bytes[4] = i_argument[7:0];
                o_frame.bytes[5] = {c7, 1'b0} | sdfc_pkg::STOP_BIT;
                o_frame.cnt      = sdfc_pkg::CNT_W'(sdfc_pkg::CMD_BYTES);
            end
            sdfc_pkg::OP_DATA: begin
                o_frame.bytes[0] = i_data_byte;
                o_frame.cnt      = sdfc_pkg::CNT_W'(1);
                o_frame.next_crc = sdfc_pkg::crc16_byte(i_crc, i_data_byte);
            end
            sdfc_pkg::OP_FINISH: begin
                o_frame.bytes[0] = fin[15:8];
                o_frame.bytes[1] = fin[7:0];
                o_frame.cnt      = sdfc_pkg::CNT_W'(2);
                o_frame.next_crc = 16'd0;
            end
            default: begin
                o_frame.cnt = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for sd_spi_frame_crc_unit: queued items feed a clocked
// driver, a clocked monitor checks each transmit byte against a local predictor.
// Depends on sdfc_pkg, sdfc_if and the RTL of sd_spi_frame_crc_unit.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT     = 15;
    localparam int HOLD_AT      = 80;
    localparam int HOLD_CYCLES  = 60;
    localparam int STALL_LIMIT  = 1000;
    localparam int SETTLE_CYCLES = 12;

    typedef struct {
        logic [1:0]  opcode;
        logic [5:0]  cmd_index;
        logic [31:0] argument;
        logic [7:0]  data_byte;
    } t_req;

    typedef struct {
        logic [7:0] tx_byte;
        logic       last;
    } t_tx_byte;

    logic clk;
    logic rst_n;

    sdfc_in_if  in_ch ();
    sdfc_out_if out_ch ();
    sdfc_cfg_if cfg_ch ();

    sd_spi_frame_crc_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    t_req       pending_q[$];
    t_tx_byte   tx_bytes_q[$];
    t_req       cur_req;
    logic [15:0] block_crc;
    logic        crc_on;
    logic        steady;
    int          mismatches;
    int          bytes_seen;
    int          hold_left;
    int          quiet_cycles;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [6:0] crc7_next(logic [6:0] crc, logic [7:0] b);
        logic [6:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[6] ^ b[i];
            c  = {c[5:0], 1'b0} ^ (fb ? 7'h09 : 7'h00);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
        end
        return c;
    endfunction

    function automatic void push_tx(logic [7:0] b, logic last);
        t_tx_byte t;
        t.tx_byte = b;
        t.last    = last;
        tx_bytes_q.push_back(t);
    endfunction

    function automatic void predict_tx_bytes(t_req r);
        logic [7:0]  frame [5];
        logic [6:0]  c7;
        logic [15:0] v;
        if (r.opcode == sdfc_pkg::OP_CMD) begin
            frame[0] = sdfc_pkg::START_BITS | {2'b00, r.cmd_index};
            frame[1] = r.argument[31:24];
            frame[2] = r.argument[23:16];
            frame[3] = r.argument[15:8];
            frame[4] = r.argument[7:0];
            c7 = '0;
            for (int k = 0; k < 5; k++) begin
                c7 = crc7_next(c7, frame[k]);
                push_tx(frame[k], 1'b0);
            end
            push_tx({c7, 1'b0} | sdfc_pkg::STOP_BIT, 1'b1);
        end else if (r.opcode == sdfc_pkg::OP_DATA) begin
            block_crc = crc16_next(block_crc, r.data_byte);
            push_tx(r.data_byte, 1'b1);
        end else if (r.opcode == sdfc_pkg::OP_FINISH) begin
            v = crc_on ? block_crc : 16'h0000;
            push_tx(v[15:8], 1'b0);
            push_tx(v[7:0], 1'b1);
            block_crc = '0;
        end
    endfunction

    function automatic t_req rand_req(logic [1:0] op);
        t_req r;
        r.opcode    = op;
        r.cmd_index = 6'($urandom);
        r.argument  = $urandom;
        r.data_byte = 8'($urandom);
        if ($urandom_range(0, 7) == 0) begin
            r.argument = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        end
        return r;
    endfunction

    function automatic void add_req(logic [1:0] op, logic [5:0] idx, logic [31:0] arg,
                                    logic [7:0] db);
        t_req r;
        r.opcode    = op;
        r.cmd_index = idx;
        r.argument  = arg;
        r.data_byte = db;
        pending_q.push_back(r);
    endfunction

    function automatic int add_random_block();
        int pick;
        int n;
        int added;
        pick  = $urandom_range(0, 99);
        added = 0;
        if (pick < 25) begin
            pending_q.push_back(rand_req(sdfc_pkg::OP_CMD));
            added = 1;
        end else if (pick < 85) begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
                pending_q.push_back(rand_req(sdfc_pkg::OP_DATA));
                if ($urandom_range(0, 5) == 0) begin
                    pending_q.push_back(rand_req(sdfc_pkg::OP_CMD));
                    added++;
                end
            end
            pending_q.push_back(rand_req(sdfc_pkg::OP_FINISH));
            added += n + 1;
        end else if (pick < 92) begin
            pending_q.push_back(rand_req(sdfc_pkg::OP_FINISH));
            added = 1;
        end else begin
            pending_q.push_back(rand_req(2'd3));
        end
        return added;
    endfunction

    task automatic drain();
        while (pending_q.size() != 0 || in_ch.valid || tx_bytes_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_crc_mode(logic value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        forever begin
            @(posedge clk);
            if (cfg_ch.ready) break;
        end
        crc_on = value;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_random(int count);
        int added;
        added = 0;
        while (added < count) begin
            added += add_random_block();
        end
        drain();
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_tx_bytes(cur_req);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    cur_req = pending_q.pop_front();
                    in_ch.opcode    <= cur_req.opcode;
                    in_ch.cmd_index <= cur_req.cmd_index;
                    in_ch.argument  <= cur_req.argument;
                    in_ch.data_byte <= cur_req.data_byte;
                    in_ch.valid     <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        t_tx_byte want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (tx_bytes_q.size() == 0) begin
                    $display("%0t: unexpected item out_byte %h last %b",
                             $realtime, out_ch.out_byte, out_ch.last);
                    mismatches++;
                end else begin
                    want = tx_bytes_q.pop_front();
                    if (out_ch.out_byte !== want.tx_byte) begin
                        $display("%0t: out_byte expected %h actual %h",
                                 $realtime, want.tx_byte, out_ch.out_byte);
                        mismatches++;
                    end
                    if (out_ch.last !== want.last) begin
                        $display("%0t: last expected %b actual %b",
                                 $realtime, want.last, out_ch.last);
                        mismatches++;
                    end
                end
                bytes_seen++;
                if (bytes_seen == HOLD_AT) begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.opcode    = '0;
        in_ch.cmd_index = '0;
        in_ch.argument  = '0;
        in_ch.data_byte = '0;
        out_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = 1'b0;
        block_crc       = '0;
        crc_on          = 1'b0;
        steady          = 1'b0;
        mismatches      = 0;
        bytes_seen      = 0;
        hold_left       = 0;
        quiet_cycles    = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        add_req(sdfc_pkg::OP_FINISH, 6'h15, 32'h1234_5678, 8'h9C);
        add_req(sdfc_pkg::OP_CMD, 6'd0, 32'h0000_0000, 8'h00);
        add_req(sdfc_pkg::OP_CMD, 6'd63, 32'hFFFF_FFFF, 8'hFF);
        add_req(sdfc_pkg::OP_DATA, 6'd0, 32'h0, 8'h00);
        add_req(sdfc_pkg::OP_DATA, 6'd63, 32'hFFFF_FFFF, 8'hFF);
        add_req(sdfc_pkg::OP_CMD, 6'd17, 32'h0000_0200, 8'h3C);
        add_req(sdfc_pkg::OP_DATA, 6'd1, 32'h0, 8'hA5);
        add_req(2'd3, 6'd63, 32'hFFFF_FFFF, 8'hFF);
        add_req(sdfc_pkg::OP_FINISH, 6'd0, 32'h0, 8'h00);
        drain();

        set_crc_mode(1'b1);
        add_req(sdfc_pkg::OP_FINISH, 6'd0, 32'h0, 8'h00);
        add_req(sdfc_pkg::OP_DATA, 6'd0, 32'h0, 8'h00);
        add_req(sdfc_pkg::OP_DATA, 6'd0, 32'h0, 8'hFF);
        add_req(sdfc_pkg::OP_CMD, 6'd8, 32'h0000_01AA, 8'h55);
        add_req(sdfc_pkg::OP_DATA, 6'd0, 32'h0, 8'h31);
        add_req(2'd3, 6'd0, 32'h0, 8'h00);
        add_req(sdfc_pkg::OP_DATA, 6'd0, 32'h0, 8'h32);
        add_req(sdfc_pkg::OP_FINISH, 6'd0, 32'h0, 8'h00);
        add_req(sdfc_pkg::OP_FINISH, 6'd0, 32'h0, 8'h00);
        add_req(sdfc_pkg::OP_CMD, 6'd55, 32'h8000_0001, 8'h00);
        drain();

        set_crc_mode(1'b0);
        run_random(30);

        set_crc_mode(1'b1);
        steady = 1'b1;
        run_random(40);
        steady = 1'b0;

        set_crc_mode(1'b0);
        set_crc_mode(1'b1);
        run_random(30);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && tx_bytes_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
